/* hw/rtl/rlbd_pkg.sv */
// Shared types and constants of the resistor ladder button decoder.
// Has no dependencies; every other file of the block imports it.
package rlbd_pkg;

    localparam int unsigned SampleWidth = 12;
    localparam int unsigned LevelWidth  = 11;
    localparam int unsigned MaskWidth   = 6;

    // Converter full scale maps to this many millivolts.
    localparam int unsigned FullMv   = 1800;
    localparam int unsigned FullCode = 4095;
    localparam int unsigned ProdWidth = SampleWidth + LevelWidth;

    localparam logic [LevelWidth-1:0] LIMIT_RESET = 11'd20;
    localparam logic [LevelWidth-1:0] BATTERY_MV  = 11'd100;

    typedef enum logic [2:0] {
        BTN_UP    = 3'd0,
        BTN_ENTER = 3'd1,
        BTN_DOWN  = 3'd2,
        BTN_RIGHT = 3'd3,
        BTN_LEFT  = 3'd4,
        BTN_BACK  = 3'd5,
        BTN_NONE  = 3'd6
    } button_t;

    typedef struct packed {
        logic [LevelWidth-1:0] level_mv;
        logic                  battery_read_enable;
        logic                  sample_stable;
        button_t               button_code;
        logic [MaskWidth-1:0]  pressed_mask;
    } result_t;

endpackage

/* hw/rtl/rlbd_eval.sv */
// Combinational evaluation of one ladder sample: scaling, settle check, classification.
// Depends on rlbd_pkg for the button codes and the result layout.
module rlbd_eval
    import rlbd_pkg::*;
(
    input  logic [SampleWidth-1:0] adc_sample,
    input  logic [LevelWidth-1:0]  previous_level,
    input  logic [LevelWidth-1:0]  stable_limit,
    input  button_t                held_button,
    output button_t                held_next,
    output result_t                result
);

    logic [ProdWidth-1:0]  prod;
    logic [ProdWidth-1:0]  est_sum;
    logic [LevelWidth-1:0] quot_est;
    logic [ProdWidth-1:0]  quot_times;
    logic [ProdWidth-1:0]  remainder;
    logic [LevelWidth-1:0] level;
    logic [LevelWidth-1:0] diff;
    logic                  settled;
    button_t               level_class;
    logic [MaskWidth-1:0]  mask;

    // Windows are open: both bounds excluded.
    function automatic button_t classify(input logic [LevelWidth-1:0] mv);
        button_t code;
        code = BTN_NONE;
        if (mv > 11'd174 && mv < 11'd274)
            code = BTN_UP;
        else if (mv > 11'd322 && mv < 11'd422)
            code = BTN_ENTER;
        else if (mv > 11'd525 && mv < 11'd625)
            code = BTN_DOWN;
        else if (mv > 11'd850 && mv < 11'd950)
            code = BTN_RIGHT;
        else if (mv > 11'd1229 && mv < 11'd1329)
            code = BTN_LEFT;
        else if (mv > 11'd1434 && mv < 11'd1534)
            code = BTN_BACK;
        return code;
    endfunction

    // Divide by 4095 as x/4096 * (1 + 1/4096); the estimate is at most one low,
    // so a single remainder compare fixes it.
    always_comb
    begin
        prod       = ProdWidth'(adc_sample) * ProdWidth'(FullMv);
        est_sum    = prod + (prod >> SampleWidth);
        quot_est   = est_sum[ProdWidth-1:SampleWidth];
        quot_times = {quot_est, {SampleWidth{1'b0}}} - ProdWidth'(quot_est);
        remainder  = prod - quot_times;
        if (remainder >= ProdWidth'(FullCode))
            level = quot_est + 1'b1;
        else
            level = quot_est;
    end

    always_comb
    begin
        if (level > previous_level)
            diff = level - previous_level;
        else
            diff = previous_level - level;
        settled     = diff < stable_limit;
        level_class = classify(level);
        held_next   = settled ? level_class : held_button;
    end

    always_comb
    begin
        case (held_next)
            BTN_UP:    mask = 6'b000001;
            BTN_ENTER: mask = 6'b000010;
            BTN_DOWN:  mask = 6'b000100;
            BTN_RIGHT: mask = 6'b001000;
            BTN_LEFT:  mask = 6'b010000;
            BTN_BACK:  mask = 6'b100000;
            default:   mask = 6'b000000;
        endcase
    end

    always_comb
    begin
        result.pressed_mask        = mask;
        result.button_code         = held_next;
        result.sample_stable       = settled;
        result.battery_read_enable = level <= BATTERY_MV;
        result.level_mv            = level;
    end

endmodule

/* hw/rtl/resistor_ladder_button_decoder_top.sv */
// Top level of the resistor ladder button decoder: stream ports, registers, state.
// Depends on rlbd_pkg and rlbd_eval.
//
// Channel   Direction  Bits  Contents
// s_axis    in         16    adc_sample
// m_axis    out        24    pressed_mask, button_code, sample_stable,
//                            battery_read_enable, level_mv
// cfg       in         11    stable_limit write
//
// A result passes through the input register and the result register, with the
// scaling, settle check and window classification between them. The block sustains
// one transaction per cycle while m_tready is high. The result register holds its
// transaction while m_tready is low, and the input register takes one more sample
// during a stall.
// Reset clears both valid flags, the previous level to zero, the held button to
// none and the stable limit to 20 mV.
module resistor_ladder_button_decoder_top
    import rlbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream. tdata: [11:0] adc_sample, [15:12] zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // Result stream. tdata: [5:0] pressed_mask, [8:6] button_code,
    // [9] sample_stable, [10] battery_read_enable, [21:11] level_mv, [23:22] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // Stable limit register write.
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data
);

    logic                   in_valid_reg;
    logic [SampleWidth-1:0] sample_reg;
    logic                   out_valid_reg;
    result_t                result_reg;
    logic [LevelWidth-1:0]  previous_level_reg;
    logic [LevelWidth-1:0]  previous_level_next;
    button_t                held_button_reg;
    button_t                held_button_next;
    logic [LevelWidth-1:0]  stable_limit_reg;
    result_t                result_next;
    logic                   out_free;
    logic                   advance;
    logic                   in_take;

    // The result register can take a new transaction when it is empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    rlbd_eval u_eval
    (
        .adc_sample     (sample_reg),
        .previous_level (previous_level_reg),
        .stable_limit   (stable_limit_reg),
        .held_button    (held_button_reg),
        .held_next      (held_button_next),
        .result         (result_next)
    );

    assign previous_level_next = result_next.level_mv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            previous_level_reg <= '0;
            held_button_reg    <= BTN_NONE;
            stable_limit_reg   <= LIMIT_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            // State moves with the sample as it enters the result register.
            if (advance)
            begin
                previous_level_reg <= previous_level_next;
                held_button_reg    <= held_button_next;
            end
            if (cfg_wr_en)
                stable_limit_reg <= cfg_wr_data;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
            sample_reg <= s_tdata[SampleWidth-1:0];
        if (advance)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result_reg};

endmodule
